@@ hdl/rthsv_pkg.sv @@
// package: types, constants and the restoring division step of the rgb to hsv converter
`timescale 1ns / 1ps

package rthsv_pkg;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] saturation;
		logic [6:0] brightness;
	} hsv_t;

	typedef enum logic [1:0] {
		SECT_RED   = 2'd0,
		SECT_GREEN = 2'd1,
		SECT_BLUE  = 2'd2
	} sector_t;

	localparam int unsigned QUO_W          = 7;
	localparam int unsigned DEN_W          = 8;
	localparam int unsigned NUM_W          = QUO_W + DEN_W;
	localparam int unsigned DIV_STAGES     = 4;
	localparam int unsigned DIV_STEPS_MAX  = 2;

	localparam logic [NUM_W-1:0] HUE_SCALE = 15'd60;
	localparam logic [NUM_W-1:0] PCT_SCALE = 15'd100;

	localparam logic [8:0] HUE_SECTOR      = 9'd60;
	localparam logic [8:0] HUE_RED_OFFSET  = 9'd300;
	localparam logic [8:0] HUE_BLUE_OFFSET = 9'd180;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] num_lo;
		logic [QUO_W-1:0] quo;
		logic [DEN_W-1:0] den;
	} div_t;

	typedef struct packed {
		div_t       hdiv;
		div_t       sdiv;
		sector_t    sector;
		logic       grey;
		logic       black;
		logic [6:0] brightness;
	} work_t;

	function automatic div_t div_step(input div_t s);
		logic [DEN_W:0] t;
		logic           qbit;
		div_t           r;
		t = {s.rem, s.num_lo[QUO_W-1]};
		r = s;
		if (t >= {1'b0, s.den}) begin
			r.rem = DEN_W'(t - {1'b0, s.den});
			qbit  = 1'b1;
		end else begin
			r.rem = t[DEN_W-1:0];
			qbit  = 1'b0;
		end
		r.num_lo = {s.num_lo[QUO_W-2:0], 1'b0};
		r.quo    = {s.quo[QUO_W-2:0], qbit};
		return r;
	endfunction

endpackage

@@ hdl/rthsv_front.sv @@
// front end: extrema and sector, then numerators, divisor set-up and brightness
`timescale 1ns / 1ps

module rthsv_front (
	input  logic             clk,
	input  logic             arst_n,
	input  rthsv_pkg::pixel_t pixel,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	output rthsv_pkg::work_t work,
	output logic             work_valid,
	input  logic             work_stall
);

	logic [7:0]         op_a_s1;
	logic [7:0]         op_c_s1;
	logic [7:0]         mx_s1;
	logic [7:0]         mn_s1;
	rthsv_pkg::sector_t sector_s1;
	logic               valid_s1;
	rthsv_pkg::work_t   work_s2;
	logic               valid_s2;

	logic               en1;
	logic               en2;
	logic [7:0]         op_a;
	logic [7:0]         op_c;
	logic [7:0]         mx;
	logic [7:0]         mn;
	logic [7:0]         mn_rg;
	rthsv_pkg::sector_t sector;

	logic [7:0]                    d;
	logic [8:0]                    span;
	logic [rthsv_pkg::NUM_W-1:0]   num_h;
	logic [rthsv_pkg::NUM_W-1:0]   num_s;
	logic [rthsv_pkg::NUM_W-1:0]   num_v;
	logic [rthsv_pkg::NUM_W:0]     vsum;
	rthsv_pkg::work_t              work_nxt;

	assign en2         = !valid_s2 || !work_stall;
	assign en1         = !valid_s1 || en2;
	assign pixel_stall = !en1;

	// stage 1: maximum, minimum and sector
	always_comb begin
		priority if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
			sector = rthsv_pkg::SECT_RED;
			mx     = pixel.red;
			op_a   = pixel.green;
			op_c   = pixel.blue;
		end else if (pixel.green >= pixel.blue) begin
			sector = rthsv_pkg::SECT_GREEN;
			mx     = pixel.green;
			op_a   = pixel.blue;
			op_c   = pixel.red;
		end else begin
			sector = rthsv_pkg::SECT_BLUE;
			mx     = pixel.blue;
			op_a   = pixel.red;
			op_c   = pixel.green;
		end
		mn_rg = (pixel.red < pixel.green) ? pixel.red : pixel.green;
		mn    = (mn_rg < pixel.blue) ? mn_rg : pixel.blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			op_a_s1   <= op_a;
			op_c_s1   <= op_c;
			mx_s1     <= mx;
			mn_s1     <= mn;
			sector_s1 <= sector;
		end
	end

	// stage 2: numerators below 128 times their divisors
	always_comb begin
		d     = mx_s1 - mn_s1;
		span  = {1'b0, op_a_s1} + {1'b0, d} - {1'b0, op_c_s1};
		num_h = {6'd0, span} * rthsv_pkg::HUE_SCALE;
		num_s = {7'd0, d} * rthsv_pkg::PCT_SCALE;
		num_v = {7'd0, mx_s1} * rthsv_pkg::PCT_SCALE;
		// divide by 255 through x + 1 + x/256
		vsum  = {1'b0, num_v} + 16'd1 + {9'd0, num_v[14:8]};

		work_nxt.hdiv.rem    = num_h[rthsv_pkg::NUM_W-1:rthsv_pkg::QUO_W];
		work_nxt.hdiv.num_lo = num_h[rthsv_pkg::QUO_W-1:0];
		work_nxt.hdiv.quo    = '0;
		work_nxt.hdiv.den    = d;
		work_nxt.sdiv.rem    = num_s[rthsv_pkg::NUM_W-1:rthsv_pkg::QUO_W];
		work_nxt.sdiv.num_lo = num_s[rthsv_pkg::QUO_W-1:0];
		work_nxt.sdiv.quo    = '0;
		work_nxt.sdiv.den    = mx_s1;
		work_nxt.sector      = sector_s1;
		work_nxt.grey        = (d == 8'd0);
		work_nxt.black       = (mx_s1 == 8'd0);
		work_nxt.brightness  = vsum[14:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			work_s2 <= work_nxt;
		end
	end

	assign work       = work_s2;
	assign work_valid = valid_s2;

endmodule

@@ hdl/rthsv_div_stage.sv @@
// one divider stage: a few restoring steps of the hue and saturation divisions
`timescale 1ns / 1ps

module rthsv_div_stage #(
	parameter int unsigned STEPS = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rthsv_pkg::work_t up,
	input  logic             up_valid,
	output logic             up_stall,
	output rthsv_pkg::work_t down,
	output logic             down_valid,
	input  logic             down_stall
);

	rthsv_pkg::work_t data_s1;
	logic             valid_s1;
	rthsv_pkg::work_t nxt;
	logic             en;

	assign en       = !valid_s1 || !down_stall;
	assign up_stall = !en;

	always_comb begin
		nxt = up;
		for (int k = 0; k < STEPS; k++) begin
			nxt.hdiv = rthsv_pkg::div_step(nxt.hdiv);
			nxt.sdiv = rthsv_pkg::div_step(nxt.sdiv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign down       = data_s1;
	assign down_valid = valid_s1;

`ifndef SYNTHESIS
	a_hrem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && data_s1.hdiv.den != 8'd0 |-> data_s1.hdiv.rem < data_s1.hdiv.den)
		else $error("hue remainder not below divisor");
	a_srem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && data_s1.sdiv.den != 8'd0 |-> data_s1.sdiv.rem < data_s1.sdiv.den)
		else $error("saturation remainder not below divisor");
	a_black_is_grey: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && data_s1.black |-> data_s1.grey)
		else $error("black item not marked grey");
`endif

endmodule

@@ hdl/rthsv_back.sv @@
// back end: hue from sector and quotient, output register
`timescale 1ns / 1ps

module rthsv_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rthsv_pkg::work_t work,
	input  logic             work_valid,
	output logic             work_stall,
	output rthsv_pkg::hsv_t  hsv,
	output logic             hsv_valid,
	input  logic             hsv_stall
);

	rthsv_pkg::hsv_t hsv_s1;
	logic            valid_s1;
	rthsv_pkg::hsv_t hsv_nxt;
	logic [8:0]      q;
	logic            en;

	assign en         = !valid_s1 || !hsv_stall;
	assign work_stall = !en;

	always_comb begin
		q = {2'b00, work.hdiv.quo};
		unique case (work.sector)
			rthsv_pkg::SECT_RED: begin
				hsv_nxt.hue = (q < rthsv_pkg::HUE_SECTOR) ? q + rthsv_pkg::HUE_RED_OFFSET
				                                          : q - rthsv_pkg::HUE_SECTOR;
			end
			rthsv_pkg::SECT_GREEN: begin
				hsv_nxt.hue = q + rthsv_pkg::HUE_SECTOR;
			end
			rthsv_pkg::SECT_BLUE: begin
				hsv_nxt.hue = q + rthsv_pkg::HUE_BLUE_OFFSET;
			end
			default: begin
				hsv_nxt.hue = '0;
			end
		endcase
		if (work.grey) begin
			hsv_nxt.hue = '0;
		end
		hsv_nxt.saturation = work.black ? 7'd0 : work.sdiv.quo;
		hsv_nxt.brightness = work.brightness;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= work_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hsv_s1 <= hsv_nxt;
		end
	end

	assign hsv       = hsv_s1;
	assign hsv_valid = valid_s1;

endmodule

@@ hdl/rgb_to_hsv_converter_top.sv @@
// top level of the rgb to hsv converter
//
//  channel | payload | handshake                | item
//  pixel   | pixel_t | pixel_valid, pixel_stall | red, green, blue
//  hsv     | hsv_t   | hsv_valid, hsv_stall     | hue, saturation, brightness
//
// one item per clock while hsv_stall is low; the pipeline has two front stages,
// four restoring-division stages (seven quotient bits) and the output stage
// every stage has its own valid bit and takes an item whenever it is empty
// or its item moves on, so bubbles close up under a stall
// reset clears only the valid bits
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top (
	input  logic              clk,
	input  logic              arst_n,
	input  rthsv_pkg::pixel_t pixel,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	output rthsv_pkg::hsv_t   hsv,
	output logic              hsv_valid,
	input  logic              hsv_stall
);

	rthsv_pkg::work_t chain_data  [rthsv_pkg::DIV_STAGES+1];
	logic             chain_valid [rthsv_pkg::DIV_STAGES+1];
	logic             chain_stall [rthsv_pkg::DIV_STAGES+1];

	rthsv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.work       (chain_data[0]),
		.work_valid (chain_valid[0]),
		.work_stall (chain_stall[0])
	);

	for (genvar i = 0; i < rthsv_pkg::DIV_STAGES; i++) begin : g_div
		localparam int unsigned STEPS_I = (i == rthsv_pkg::DIV_STAGES - 1) ?
			rthsv_pkg::QUO_W - rthsv_pkg::DIV_STEPS_MAX * (rthsv_pkg::DIV_STAGES - 1) :
			rthsv_pkg::DIV_STEPS_MAX;
		rthsv_div_stage #(
			.STEPS(STEPS_I)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.up        (chain_data[i]),
			.up_valid  (chain_valid[i]),
			.up_stall  (chain_stall[i]),
			.down      (chain_data[i+1]),
			.down_valid(chain_valid[i+1]),
			.down_stall(chain_stall[i+1])
		);
	end

	rthsv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.work      (chain_data[rthsv_pkg::DIV_STAGES]),
		.work_valid(chain_valid[rthsv_pkg::DIV_STAGES]),
		.work_stall(chain_stall[rthsv_pkg::DIV_STAGES]),
		.hsv       (hsv),
		.hsv_valid (hsv_valid),
		.hsv_stall (hsv_stall)
	);

`ifndef SYNTHESIS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hsv.hue < 9'd360)
		else $error("hue out of range");
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hsv.saturation <= 7'd100)
		else $error("saturation out of range");
	a_val_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hsv.brightness <= 7'd100)
		else $error("brightness out of range");
`endif

endmodule

@@ verif/rgb_to_hsv_converter_top_tb.sv @@
// testbench of the rgb to hsv converter: directed and random pixels checked against a predictor
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top_tb;

	localparam int unsigned HUE_STEP     = 60;
	localparam int unsigned HUE_RED_BASE = 360;
	localparam int unsigned HUE_GRN_BASE = 120;
	localparam int unsigned HUE_BLU_BASE = 240;
	localparam int unsigned HUE_TURN     = 360;
	localparam int unsigned PERCENT      = 100;
	localparam int unsigned FULL_SCALE   = 255;
	localparam int unsigned RANDOM_ITEMS = 200;
	localparam int unsigned TAIL_CYCLES  = 16;
	localparam int unsigned STALL_LIMIT  = 2000;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	rthsv_pkg::pixel_t pixel       = '0;
	logic              pixel_valid = 1'b0;
	logic              pixel_stall;
	rthsv_pkg::hsv_t   hsv;
	logic              hsv_valid;
	logic              hsv_stall   = 1'b0;

	rthsv_pkg::pixel_t pending_pixels[$];
	rthsv_pkg::hsv_t   expected_hsv[$];
	logic   pix_taken      = 1'b0;
	int     sender_idle_pct = 0;
	int     recv_stall_pct  = 0;
	int     queued_count    = 0;
	int     sent_count      = 0;
	int     idle_cycles     = 0;
	int     errors          = 0;

	rgb_to_hsv_converter_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.hsv         (hsv),
		.hsv_valid   (hsv_valid),
		.hsv_stall   (hsv_stall)
	);

	function automatic rthsv_pkg::hsv_t hsv_of_pixel(input rthsv_pkg::pixel_t p);
		int unsigned     r, g, b, mx, mn, d, hue, sat;
		rthsv_pkg::hsv_t h;
		r  = p.red;
		g  = p.green;
		b  = p.blue;
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		d  = mx - mn;
		if (d == 0) begin
			hue = 0;
		end else if (mx == r) begin
			hue = ((HUE_STEP * g + HUE_RED_BASE * d - HUE_STEP * b) / d) % HUE_TURN;
		end else if (mx == g) begin
			hue = (HUE_STEP * b + HUE_GRN_BASE * d - HUE_STEP * r) / d;
		end else begin
			hue = (HUE_STEP * r + HUE_BLU_BASE * d - HUE_STEP * g) / d;
		end
		sat          = (mx == 0) ? 0 : (PERCENT * d) / mx;
		h.hue        = 9'(hue);
		h.saturation = 7'(sat);
		h.brightness = 7'((PERCENT * mx) / FULL_SCALE);
		return h;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: hsv %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic queue_pixel(input int r, input int g, input int b);
		rthsv_pkg::pixel_t p;
		p.red   = 8'(r);
		p.green = 8'(g);
		p.blue  = 8'(b);
		pending_pixels.push_back(p);
		queued_count++;
	endtask

	task automatic queue_random_pixels(input int count);
		int v, w, k;
		for (int i = 0; i < count; i++) begin
			v = $urandom_range(255);
			w = $urandom_range(255);
			k = $urandom_range(9);
			case (k)
				6: begin
					queue_pixel(v, v, v);
				end
				7: begin
					// two components share the maximum
					if (w > v) begin
						v = w;
						w = $urandom_range(v);
					end
					case ($urandom_range(2))
						0: queue_pixel(v, v, w);
						1: queue_pixel(w, v, v);
						default: queue_pixel(v, w, v);
					endcase
				end
				8: begin
					queue_pixel($urandom_range(3), $urandom_range(3), $urandom_range(3));
				end
				9: begin
					queue_pixel($urandom_range(1) * 255, $urandom_range(1) * 255, v);
				end
				default: begin
					queue_pixel(v, w, $urandom_range(255));
				end
			endcase
		end
	endtask

	task automatic wait_for_drain();
		do @(negedge clk); while (sent_count != queued_count || expected_hsv.size() != 0);
		@(posedge clk);
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!pixel_valid || pix_taken) begin
				if (pending_pixels.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					pixel       <= pending_pixels.pop_front();
					pixel_valid <= 1'b1;
				end else begin
					pixel_valid <= 1'b0;
				end
			end
			hsv_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		rthsv_pkg::hsv_t want;
		logic            moved;
		if (arst_n) begin
			moved = 1'b0;
			pix_taken <= pixel_valid && !pixel_stall;
			if (pixel_valid && !pixel_stall) begin
				expected_hsv.push_back(hsv_of_pixel(pixel));
				sent_count <= sent_count + 1;
				moved = 1'b1;
			end
			if (hsv_valid && !hsv_stall) begin
				moved = 1'b1;
				if (expected_hsv.size() == 0) begin
					$display("%0t: hsv item with none expected", $realtime);
					errors++;
				end else begin
					want = expected_hsv.pop_front();
					if (hsv.hue !== want.hue)
						report_mismatch("hue", hsv.hue, want.hue);
					if (hsv.saturation !== want.saturation)
						report_mismatch("saturation", hsv.saturation, want.saturation);
					if (hsv.brightness !== want.brightness)
						report_mismatch("brightness", hsv.brightness, want.brightness);
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("rgb_to_hsv_converter_top_tb failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// black, white, grey, primaries, ties and the hue wrap
		queue_pixel(0, 0, 0);
		queue_pixel(255, 255, 255);
		queue_pixel(128, 128, 128);
		queue_pixel(255, 0, 0);
		queue_pixel(0, 255, 0);
		queue_pixel(0, 0, 255);
		queue_pixel(255, 255, 0);
		queue_pixel(0, 255, 255);
		queue_pixel(255, 0, 255);
		queue_pixel(1, 0, 0);
		queue_pixel(0, 1, 0);
		queue_pixel(0, 0, 1);
		queue_pixel(255, 0, 1);
		queue_pixel(255, 1, 0);
		queue_pixel(1, 1, 0);
		queue_pixel(0, 1, 1);
		queue_pixel(254, 255, 255);
		queue_pixel(255, 254, 254);
		queue_pixel(170, 85, 0);
		queue_pixel(0, 170, 85);
		queue_pixel(85, 0, 170);
		queue_pixel(1, 255, 254);
		queue_random_pixels(RANDOM_ITEMS);
		wait_for_drain();

		sender_idle_pct = 76;
		recv_stall_pct  = 0;
		queue_random_pixels(RANDOM_ITEMS);
		wait_for_drain();

		sender_idle_pct = 0;
		recv_stall_pct  = 76;
		queue_random_pixels(RANDOM_ITEMS);
		wait_for_drain();

		sender_idle_pct = 17;
		recv_stall_pct  = 17;
		queue_random_pixels(RANDOM_ITEMS);
		wait_for_drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_hsv.size() != 0) begin
			$display("%0d hsv items never arrived", expected_hsv.size());
			errors++;
		end
		if (errors == 0) begin
			$display("rgb_to_hsv_converter_top_tb passed");
		end else begin
			$display("rgb_to_hsv_converter_top_tb failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/rthsv_pkg.sv
hdl/rthsv_front.sv
hdl/rthsv_div_stage.sv
hdl/rthsv_back.sv
hdl/rgb_to_hsv_converter_top.sv
verif/rgb_to_hsv_converter_top_tb.sv
